// ===== src/vrp_pkg.sv =====
// Shared types and constants for the vertex rotate/project pipeline.
// No dependencies; imported by vrp_div and vertex_rotate_project_z16_top.
`default_nettype none
package vrp_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned ScrW   = 20;
  localparam int unsigned QuoW   = 17;
  localparam int unsigned DenW   = 23;
  localparam int unsigned RemW   = 24;

  localparam logic signed [26:0] CamOffset = 27'sd301466;
  localparam logic [16:0]        FarQ      = 17'd9362;
  localparam logic [16:0]        NearQ     = 17'd26214;
  localparam logic [15:0]        QMax      = 16'd65535;
  localparam logic [15:0]        Z16Max    = 16'd65535;
  localparam logic [15:0]        Z16Min    = 16'd1;

  // floor(p / 8426) == (p * ZRecip) >> ZShift for p below 2^30
  localparam int unsigned  ZShift = 44;
  localparam logic [63:0]  ZRecip64 = ((64'd1 << ZShift) + 64'd8426 - 64'd1) / 64'd8426;
  localparam logic [30:0]  ZRecip = ZRecip64[30:0];

  typedef enum logic [2:0] {
    REG_SIN_YAW   = 3'd0,
    REG_COS_YAW   = 3'd1,
    REG_SIN_PITCH = 3'd2,
    REG_COS_PITCH = 3'd3,
    REG_CENTER_X  = 3'd4,
    REG_CENTER_Y  = 3'd5,
    REG_FOCAL     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [18:0] rx;
    logic signed [21:0] ry;
    logic               clip;
  } div_side_t;

endpackage
`default_nettype wire

// ===== src/vrp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on vrp_pkg.
`default_nettype none
module vrp_div
  import vrp_pkg::*;
#(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [RemW-1:0]   in_rem,
  input  wire logic [QuoW-1:0]   in_low,
  input  wire logic [DenW-1:0]   in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [QuoW-1:0]        out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  logic              vld_r  [0:QuoW];
  logic [RemW-1:0]   rem_r  [0:QuoW];
  logic [QuoW-1:0]   low_r  [0:QuoW];
  logic [QuoW-1:0]   quo_r  [0:QuoW];
  logic [DenW-1:0]   den_r  [0:QuoW];
  logic [SIDE_W-1:0] side_r [0:QuoW];

  always_comb begin
    vld_r[0]  = in_valid;
    rem_r[0]  = in_rem;
    low_r[0]  = in_low;
    quo_r[0]  = '0;
    den_r[0]  = in_den;
    side_r[0] = in_side;
  end

  for (genvar k = 1; k <= QuoW; k++) begin : g_step
    logic [RemW-1:0] trial;
    logic            ge;
    always_comb begin
      trial = {rem_r[k-1][RemW-2:0], low_r[k-1][QuoW-1]};
      ge    = (trial >= {1'b0, den_r[k-1]});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
      if (en) begin
        rem_r[k]  <= ge ? (trial - {1'b0, den_r[k-1]}) : trial;
        low_r[k]  <= {low_r[k-1][QuoW-2:0], 1'b0};
        quo_r[k]  <= {quo_r[k-1][QuoW-2:0], ge};
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[QuoW];
  assign out_quo   = quo_r[QuoW];
  assign out_side  = side_r[QuoW];

endmodule
`default_nettype wire

// ===== src/vertex_rotate_project_z16_top.sv =====
// Top level: rotation, camera offset, reciprocal depth, projection, Z16 map.
// Depends on vrp_pkg and vrp_div.
//
//  channel | dir | payload
//  in_     | in  | tdata: vertex_x, vertex_y, vertex_z
//  out_    | out | tdata: screen_x, screen_y, recip_depth, depth_z16; tuser: near_clipped
//  cfg_    | in  | we, idx, wdata (seven 16-bit registers)
//
// One vertex per clock unless stalled; 4 rotate stages, 17 divider stages
// (one quotient bit each), 3 projection stages, output register.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage. Reset clears valid bits and sets config defaults.
`default_nettype none
module vertex_rotate_project_z16_top
  import vrp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // vertex_x, vertex_y, vertex_z
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // screen_x, screen_y, recip_depth, depth_z16
  output logic             out_tuser,  // near_clipped
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata
);

  localparam int unsigned SideW = $bits(div_side_t);

  logic signed [15:0] sin_yaw_r, cos_yaw_r, sin_pitch_r, cos_pitch_r;
  logic [15:0]        ctr_x_r, ctr_y_r, focal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sin_yaw_r   <= 16'sd0;
      cos_yaw_r   <= 16'sd16384;
      sin_pitch_r <= 16'sd0;
      cos_pitch_r <= 16'sd16384;
      ctr_x_r     <= '0;
      ctr_y_r     <= '0;
      focal_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SIN_YAW:   sin_yaw_r   <= cfg_wdata;
        REG_COS_YAW:   cos_yaw_r   <= cfg_wdata;
        REG_SIN_PITCH: sin_pitch_r <= cfg_wdata;
        REG_COS_PITCH: cos_pitch_r <= cfg_wdata;
        REG_CENTER_X:  ctr_x_r     <= cfg_wdata;
        REG_CENTER_Y:  ctr_y_r     <= cfg_wdata;
        REG_FOCAL:     focal_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // stage 1: yaw products
  logic               v1_r;
  logic signed [31:0] pxc_r, pzs_r, pxs_r, pzc_r;
  logic signed [15:0] y1_r;
  logic signed [15:0] vx, vy, vz;
  assign vx = in_tdata[15:0];
  assign vy = in_tdata[31:16];
  assign vz = in_tdata[47:32];

  // stage 2: yaw sums
  logic               v2_r;
  logic signed [18:0] rx2_r, rz0_r;
  logic signed [15:0] y2_r;
  logic signed [32:0] rx_sum, rz_sum;
  assign rx_sum = 33'(pxc_r) + 33'(pzs_r) + 33'sd8192;
  assign rz_sum = 33'(pzc_r) - 33'(pxs_r) + 33'sd8192;

  // stage 3: pitch products
  logic               v3_r;
  logic signed [31:0] pyc_r, pys_r;
  logic signed [34:0] pzs3_r, pzc3_r;
  logic signed [18:0] rx3_r;

  // stage 4: pitch sums, camera depth
  logic               v4_r;
  logic signed [35:0] ry_sum, rz_full;
  logic signed [26:0] cz;
  logic               clip4;
  logic [DenW-1:0]    den4_r;
  logic [RemW-1:0]    rem4_r;
  logic [QuoW-1:0]    low4_r;
  div_side_t          side4_r;
  assign ry_sum  = 36'(pyc_r) - 36'(pzs3_r) + 36'sd8192;
  assign rz_full = 36'(pys_r) + 36'(pzc3_r) + 36'sd512;
  assign cz      = 27'($signed(rz_full[35:10])) + CamOffset;
  assign clip4   = (cz < 27'sd65536);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    if (adv) begin
      pxc_r  <= vx * cos_yaw_r;
      pzs_r  <= vz * sin_yaw_r;
      pxs_r  <= vx * sin_yaw_r;
      pzc_r  <= vz * cos_yaw_r;
      y1_r   <= vy;
      rx2_r  <= rx_sum[32:14];
      rz0_r  <= rz_sum[32:14];
      y2_r   <= y1_r;
      pyc_r  <= y2_r * cos_pitch_r;
      pys_r  <= y2_r * sin_pitch_r;
      pzs3_r <= rz0_r * sin_pitch_r;
      pzc3_r <= rz0_r * cos_pitch_r;
      rx3_r  <= rx2_r;
      den4_r <= clip4 ? DenW'(1) : cz[DenW-1:0];
      rem4_r <= RemW'(16'd32768 + {11'd0, cz[22:18]});
      low4_r <= cz[17:1];
      side4_r.rx   <= rx3_r;
      side4_r.ry   <= ry_sum[35:14];
      side4_r.clip <= clip4;
    end
  end

  logic              vd;
  logic [QuoW-1:0]   quo;
  logic [SideW-1:0]  side_bits;
  div_side_t         sided;

  vrp_div #(
    .SIDE_W(SideW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v4_r),
    .in_rem   (rem4_r),
    .in_low   (low4_r),
    .in_den   (den4_r),
    .in_side  (side4_r),
    .out_valid(vd),
    .out_quo  (quo),
    .out_side (side_bits)
  );
  assign sided = side_bits;

  // P1: saturate q, focal products, depth offset
  logic               p1v_r;
  logic [15:0]        q1_r;
  logic               c1_r, far1_r, near1_r;
  logic signed [35:0] pfx_r;
  logic signed [38:0] pfy_r;
  logic [29:0]        zp_r;
  logic [15:0]        qs;
  logic [16:0]        zd;
  logic signed [16:0] foc_s;
  assign qs    = (sided.clip || quo[16]) ? QMax : quo[15:0];
  assign zd    = {1'b0, qs} - FarQ;
  assign foc_s = $signed({1'b0, focal_r});

  // P2: scale by q, Z16 reciprocal multiply
  logic               p2v_r;
  logic [15:0]        q2_r;
  logic               c2_r, far2_r, near2_r;
  logic signed [52:0] prx_r;
  logic signed [55:0] pry_r;
  logic [60:0]        zm_r;
  logic signed [16:0] q_s;
  assign q_s = $signed({1'b0, q1_r});

  // P3: round projections, select Z16
  logic               p3v_r;
  logic [15:0]        q3_r, zz3_r;
  logic               c3_r;
  logic signed [24:0] sx3_r;
  logic signed [27:0] sy3_r;
  logic signed [52:0] prx_rnd;
  logic signed [55:0] pry_rnd;
  assign prx_rnd = prx_r + 53'sd134217728;
  assign pry_rnd = pry_r + 56'sd134217728;

  // output: add centre, saturate
  logic signed [28:0] scx, scy;
  logic signed [19:0] scx_sat, scy_sat;
  logic [15:0]        q_o_r, zz_o_r;
  logic               c_o_r;
  logic signed [19:0] sx_o_r, sy_o_r;
  logic               ov_r;
  assign scx = $signed({13'd0, ctr_x_r}) + 29'(sx3_r);
  assign scy = $signed({13'd0, ctr_y_r}) - 29'(sy3_r);
  assign scx_sat = (scx > 29'sd524287) ? 20'sd524287 :
                   (scx < -29'sd524288) ? -20'sd524288 : scx[19:0];
  assign scy_sat = (scy > 29'sd524287) ? 20'sd524287 :
                   (scy < -29'sd524288) ? -20'sd524288 : scy[19:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1v_r <= 1'b0;
      p2v_r <= 1'b0;
      p3v_r <= 1'b0;
      ov_r  <= 1'b0;
    end else if (adv) begin
      p1v_r <= vd;
      p2v_r <= p1v_r;
      p3v_r <= p2v_r;
      ov_r  <= p3v_r;
    end
    if (adv) begin
      q1_r    <= qs;
      c1_r    <= sided.clip;
      far1_r  <= ({1'b0, qs} <= FarQ);
      near1_r <= ({1'b0, qs} >= NearQ);
      pfx_r   <= sided.rx * foc_s;
      pfy_r   <= sided.ry * foc_s;
      zp_r    <= 30'({zd[14:0], 15'd0}) - 30'(zd[14:0]);
      q2_r    <= q1_r;
      c2_r    <= c1_r;
      far2_r  <= far1_r;
      near2_r <= near1_r;
      prx_r   <= pfx_r * q_s;
      pry_r   <= pfy_r * q_s;
      zm_r    <= 61'(zp_r) * 61'(ZRecip);
      q3_r    <= q2_r;
      c3_r    <= c2_r;
      sx3_r   <= prx_rnd[52:28];
      sy3_r   <= pry_rnd[55:28];
      zz3_r   <= far2_r ? Z16Min : (near2_r ? Z16Max : 16'(17'd1 + zm_r[60:44]));
      q_o_r   <= q3_r;
      zz_o_r  <= zz3_r;
      c_o_r   <= c3_r;
      sx_o_r  <= scx_sat;
      sy_o_r  <= scy_sat;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {zz_o_r, q_o_r, sy_o_r, sx_o_r};
  assign out_tuser  = c_o_r;

endmodule
`default_nettype wire
